// ===== design/tmrf_pkg.sv =====
package tmrf_pkg;

  // history geometry
  localparam int MaxHistory = 8;
  localparam int MaxRays    = 1024;

  // field widths
  localparam int RayW   = 10;
  localparam int RangeW = 16;
  localparam int WinW   = 4;
  localparam int CntW   = $clog2(MaxHistory + 1);
  localparam int SlotW  = (MaxHistory > 1) ? $clog2(MaxHistory) : 1;
  localparam int AddrW  = SlotW + RayW;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CfgFilterEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowSize   = 1'd1;

  localparam logic             FilterEnableRst = 1'b1;
  localparam logic [WinW-1:0]  WindowSizeRst   = 4'd5;

  // sequencer to sorter
  typedef struct packed {
    logic              clr;
    logic              load;
    logic [RangeW-1:0] key;
  } sort_ctrl_t;

  // sorter to sequencer
  typedef struct packed {
    logic              busy;
    logic [CntW-1:0]   cnt;
    logic [RangeW-1:0] median;
  } sort_stat_t;

endpackage

// ===== design/tmrf_hist_mem.sv =====
module tmrf_hist_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tmrf_pkg::AddrW-1:0]  waddr_i,
  input  logic [tmrf_pkg::RangeW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [tmrf_pkg::AddrW-1:0]  raddr_i,
  output logic [tmrf_pkg::RangeW-1:0] rdata_o
);

  localparam int Depth = 2 ** tmrf_pkg::AddrW;

  logic [tmrf_pkg::RangeW-1:0] mem [Depth];
  logic [tmrf_pkg::RangeW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tmrf_sorter.sv =====
module tmrf_sorter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmrf_pkg::sort_ctrl_t  ctrl_i,
  output tmrf_pkg::sort_stat_t  stat_o
);

  logic [tmrf_pkg::RangeW-1:0] vals_q [tmrf_pkg::MaxHistory];
  logic [tmrf_pkg::RangeW-1:0] vals_d [tmrf_pkg::MaxHistory];
  logic [tmrf_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic [tmrf_pkg::SlotW-1:0]  p_q, p_d;
  logic [tmrf_pkg::RangeW-1:0] key_q, key_d;
  logic [tmrf_pkg::SlotW-1:0]  ridx;
  logic [tmrf_pkg::RangeW-1:0] rd_val;

  // single read port: neighbor below the hole while inserting, median otherwise
  assign ridx   = busy_q ? (p_q - 1'b1) : tmrf_pkg::SlotW'(cnt_q >> 1);
  assign rd_val = vals_q[ridx];

  always_comb begin
    vals_d = vals_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    p_d    = p_q;
    key_d  = key_q;
    if (busy_q) begin
      // one compare per cycle, shift larger entry up or drop key in
      if (p_q != '0 && rd_val > key_q) begin
        vals_d[p_q] = rd_val;
        p_d         = p_q - 1'b1;
      end else begin
        vals_d[p_q] = key_q;
        cnt_d       = cnt_q + 1'b1;
        busy_d      = 1'b0;
      end
    end
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end
    if (ctrl_i.load) begin
      key_d  = ctrl_i.key;
      p_d    = ctrl_i.clr ? '0 : cnt_q[tmrf_pkg::SlotW-1:0];
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vals_q <= vals_d;
    p_q    <= p_d;
    key_q  <= key_d;
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.cnt    = cnt_q;
  assign stat_o.median = (cnt_q == '0) ? '0 : rd_val;

endmodule

// ===== design/temporal_median_range_filter_unit.sv =====
// unfiltered items and rays out of range go straight to the output register; filtered items
// read each older scan in the window in turn and insert the current and every nonzero value
// one item at a time, as the single compare/insert unit and one history port set it, and a
// stalled result holds the next item
// reset: filter enabled, window 5, slot 0, no scans held; history contents undefined
// and never cleared, so it is valid only once each scan slot has been written for that ray
module temporal_median_range_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [tmrf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmrf_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tmrf_pkg::RayW-1:0]     ray_index_i,
  input  logic [tmrf_pkg::RangeW-1:0]   range_mm_i,
  input  logic                          end_of_scan_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmrf_pkg::RayW-1:0]     out_ray_index_o,
  output logic [tmrf_pkg::RangeW-1:0]   filtered_range_mm_o,
  output logic [tmrf_pkg::CntW-1:0]     valid_count_o,
  output logic                          out_end_of_scan_o
);

  typedef enum logic [2:0] {
    StIdle,
    StFetch,   // issue read of next older scan
    StLoad,    // history word back, hand to sorter if nonzero
    StSort,    // wait for insertion to finish
    StDone     // park result in output register
  } state_e;

  localparam int CntW  = tmrf_pkg::CntW;
  localparam int SlotW = tmrf_pkg::SlotW;
  localparam int RangeW = tmrf_pkg::RangeW;

  state_e state_q, state_d;

  // configuration
  logic                     en_q, en_d;
  logic [tmrf_pkg::WinW-1:0] win_q, win_d;

  // scan ring bookkeeping
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] held_q, held_d;

  // current item
  logic [tmrf_pkg::RayW-1:0] ray_q, ray_d;
  logic [RangeW-1:0]         range_q, range_d;
  logic                      eos_q, eos_d;
  logic                      filt_q, filt_d;
  logic [SlotW-1:0]          rd_slot_q, rd_slot_d;
  logic [CntW-1:0]           k_q, k_d;
  logic [CntW-1:0]           n_q, n_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [tmrf_pkg::RayW-1:0] out_ray_q, out_ray_d;
  logic [RangeW-1:0]         out_range_q, out_range_d;
  logic [CntW-1:0]           out_cnt_q, out_cnt_d;
  logic                      out_eos_q, out_eos_d;

  // history memory port signals
  logic                       mem_we, mem_re;
  logic [tmrf_pkg::AddrW-1:0] mem_waddr, mem_raddr;
  logic [RangeW-1:0]          mem_rdata;

  tmrf_pkg::sort_ctrl_t sort_ctrl;
  tmrf_pkg::sort_stat_t sort_stat;

  // effective window and clamped count of older scans
  logic [CntW-1:0]  win_eff;
  logic [CntW-1:0]  win_m1;
  logic [SlotW-1:0] held_clip;
  logic             ray_ok;
  logic [SlotW-1:0] slot_inc;
  logic [SlotW-1:0] rd_slot_dec;
  logic             out_free;

  always_comb begin
    if (win_q == '0) begin
      win_eff = CntW'(1);
    end else if ({1'b0, win_q} > 5'(tmrf_pkg::MaxHistory)) begin
      win_eff = CntW'(tmrf_pkg::MaxHistory);
    end else begin
      win_eff = CntW'(win_q);
    end
  end

  assign win_m1    = win_eff - 1'b1;
  assign held_clip = (CntW'(held_q) > win_m1) ? win_m1[SlotW-1:0] : held_q;
  assign ray_ok    = (32'(ray_index_i) < tmrf_pkg::MaxRays);

  // ring pointer steps, written out so a non power of two depth still wraps
  assign slot_inc    = (slot_q == SlotW'(tmrf_pkg::MaxHistory - 1)) ? '0 : slot_q + 1'b1;
  assign rd_slot_dec = (rd_slot_q == '0) ? SlotW'(tmrf_pkg::MaxHistory - 1)
                                         : rd_slot_q - 1'b1;

  // output register can take a new result
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    win_d       = win_q;
    slot_d      = slot_q;
    held_d      = held_q;
    ray_d       = ray_q;
    range_d     = range_q;
    eos_d       = eos_q;
    filt_d      = filt_q;
    rd_slot_d   = rd_slot_q;
    k_d         = k_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    out_ray_d   = out_ray_q;
    out_range_d = out_range_q;
    out_cnt_d   = out_cnt_q;
    out_eos_d   = out_eos_q;

    mem_we    = 1'b0;
    mem_waddr = {slot_q, ray_index_i};
    mem_re    = 1'b0;
    mem_raddr = {rd_slot_dec, ray_q};

    sort_ctrl.clr  = 1'b0;
    sort_ctrl.load = 1'b0;
    sort_ctrl.key  = range_mm_i;

    // downstream took the result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // the user must write registers only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tmrf_pkg::CfgFilterEnable: en_d  = cfg_data_i[0];
        tmrf_pkg::CfgWindowSize:   win_d = cfg_data_i[tmrf_pkg::WinW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ray_d   = ray_index_i;
          range_d = range_mm_i;
          eos_d   = end_of_scan_i;
          filt_d  = 1'b0;
          state_d = StDone;
          if (en_q) begin
            // current sample goes in its slot and, if nonzero, feeds the sorter directly
            filt_d    = ray_ok;
            n_d       = CntW'(held_clip) + 1'b1;
            k_d       = CntW'(1);
            rd_slot_d = slot_q;
            held_d    = held_clip;
            if (ray_ok) begin
              mem_we        = 1'b1;
              sort_ctrl.clr = 1'b1;
              if (range_mm_i != '0) begin
                sort_ctrl.load = 1'b1;
                state_d        = StSort;
              end else begin
                state_d = StFetch;
              end
            end
            // scan bookkeeping moves now; the reads use the saved slot
            if (end_of_scan_i) begin
              slot_d = slot_inc;
              if (CntW'(held_clip) < CntW'(tmrf_pkg::MaxHistory - 1)) begin
                held_d = held_clip + 1'b1;
              end
            end
          end
        end
      end
      StFetch: begin
        if (k_q < n_q) begin
          mem_re    = 1'b1;
          rd_slot_d = rd_slot_dec;
          k_d       = k_q + 1'b1;
          state_d   = StLoad;
        end else begin
          state_d = StDone;
        end
      end
      StLoad: begin
        sort_ctrl.key = mem_rdata;
        if (mem_rdata != '0) begin
          sort_ctrl.load = 1'b1;
          state_d        = StSort;
        end else begin
          state_d = StFetch;
        end
      end
      StSort: begin
        if (!sort_stat.busy) begin
          state_d = StFetch;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ray_d   = ray_q;
          out_eos_d   = eos_q;
          out_range_d = filt_q ? sort_stat.median : range_q;
          out_cnt_d   = filt_q ? sort_stat.cnt : '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      en_q        <= tmrf_pkg::FilterEnableRst;
      win_q       <= tmrf_pkg::WindowSizeRst;
      slot_q      <= '0;
      held_q      <= '0;
      ray_q       <= '0;
      range_q     <= '0;
      eos_q       <= 1'b0;
      filt_q      <= 1'b0;
      rd_slot_q   <= '0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_ray_q   <= '0;
      out_range_q <= '0;
      out_cnt_q   <= '0;
      out_eos_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      win_q       <= win_d;
      slot_q      <= slot_d;
      held_q      <= held_d;
      ray_q       <= ray_d;
      range_q     <= range_d;
      eos_q       <= eos_d;
      filt_q      <= filt_d;
      rd_slot_q   <= rd_slot_d;
      k_q         <= k_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      out_ray_q   <= out_ray_d;
      out_range_q <= out_range_d;
      out_cnt_q   <= out_cnt_d;
      out_eos_q   <= out_eos_d;
    end
  end

  tmrf_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (range_mm_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tmrf_sorter u_sorter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sort_ctrl),
    .stat_o (sort_stat)
  );

  assign in_ready_o          = (state_q == StIdle);
  assign out_valid_o         = out_valid_q;
  assign out_ray_index_o     = out_ray_q;
  assign filtered_range_mm_o = out_range_q;
  assign valid_count_o       = out_cnt_q;
  assign out_end_of_scan_o   = out_eos_q;

  // a transfer in closes the input side for at least the next cycle
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // the history port is only read while the sorter is idle
  a_fetch_sorter_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFetch |-> !sort_stat.busy)
    else $error("fetch while sorter busy");

  // sorter never holds more values than scans read so far
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle && filt_q |-> sort_stat.cnt <= k_q)
    else $error("sorter count exceeds scans read");

  // reported count never exceeds the history depth
  a_out_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> valid_count_o <= CntW'(tmrf_pkg::MaxHistory))
    else $error("valid count beyond history depth");

  // no read is issued beyond the window
  a_read_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> k_q < n_q && n_q <= CntW'(tmrf_pkg::MaxHistory))
    else $error("history read outside window");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int RayW = tmrf_pkg::RayW;
  localparam int RangeW = tmrf_pkg::RangeW;
  localparam int CntW = tmrf_pkg::CntW;
  localparam int WinW = tmrf_pkg::WinW;
  localparam int CfgIdxW = tmrf_pkg::CfgIdxW;
  localparam int CfgDataW = tmrf_pkg::CfgDataW;
  localparam int MaxHistory = tmrf_pkg::MaxHistory;
  localparam int MaxRays = tmrf_pkg::MaxRays;

  localparam int HalfPeriod = 5;
  localparam int ResetCycles = 7;
  localparam int MaxPause = 12;
  // no transfer for this long means the block is hung
  localparam int StallLimit = 2000;
  // extra time at the end so that any tail of results can come out
  localparam int DrainCycles = 64;
  // rays in one well formed scan
  localparam int ScanRays = 8;
  localparam int PrintLimit = 40;
  localparam int NumPhases = 9;

  typedef struct packed {
    logic [RayW-1:0]   ray;
    logic [RangeW-1:0] mm;
    logic              eos;
  } sample_t;

  typedef struct packed {
    logic [RayW-1:0]   ray;
    logic [RangeW-1:0] mm;
    logic [CntW-1:0]   cnt;
    logic              eos;
  } median_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [RayW-1:0] ray_index_i = '0;
  logic [RangeW-1:0] range_mm_i = '0;
  logic end_of_scan_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RayW-1:0] out_ray_index_o;
  logic [RangeW-1:0] filtered_range_mm_o;
  logic [CntW-1:0] valid_count_o;
  logic out_end_of_scan_o;

  temporal_median_range_filter_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .ray_index_i,
    .range_mm_i,
    .end_of_scan_i,
    .out_valid_o,
    .out_ready_i,
    .out_ray_index_o,
    .filtered_range_mm_o,
    .valid_count_o,
    .out_end_of_scan_o
  );

  always #HalfPeriod clk_i = ~clk_i;

  // samples waiting to be driven, and medians waiting to come out
  sample_t sample_q[$];
  median_t median_q[$];
  int mismatch_cnt = 0;

  // register shadow, written only while the block is idle
  logic flt_en = tmrf_pkg::FilterEnableRst;
  logic [WinW-1:0] win_cfg = tmrf_pkg::WindowSizeRst;

  // history as the block should hold it, updated on each input transfer
  logic [RangeW-1:0] hist_mm [MaxHistory][MaxRays];
  int unsigned cur_slot = 0;
  int unsigned held_scans = 0;

  // stimulus side bookkeeping: which history entries have been written, so
  // that no item ever makes the block read an entry it never wrote
  bit gen_written [MaxHistory][MaxRays];
  int unsigned gen_slot = 0;
  int unsigned gen_held = 0;
  logic [RayW-1:0] gen_last = '0;

  // window 0 acts as 1, anything above the history depth acts as the depth
  function automatic int unsigned eff_window();
    int unsigned w;
    w = win_cfg;
    if (w < 1) w = 1;
    if (w > MaxHistory) w = MaxHistory;
    return w;
  endfunction

  // upper median over the newest window of scans for this ray
  function automatic median_t median_of_history(input logic [RayW-1:0] ray,
                                                input logic [RangeW-1:0] mm,
                                                input logic eos);
    median_t res;
    logic [RangeW-1:0] sorted [MaxHistory];
    logic [RangeW-1:0] v;
    int unsigned w;
    int n;
    int k;
    int p;
    int cnt;
    res.ray = ray;
    res.mm = mm;
    res.cnt = '0;
    res.eos = eos;
    if (flt_en) begin
      w = eff_window();
      // shrinking the window drops older scans for good
      if (held_scans > w - 1) held_scans = w - 1;
      if (int'(ray) < MaxRays) begin
        hist_mm[cur_slot][ray] = mm;
        n = held_scans + 1;
        cnt = 0;
        for (k = 0; k < n; k++) begin
          v = hist_mm[(cur_slot + MaxHistory - k) % MaxHistory][ray];
          // zero means no return and stays out of the median
          if (v != '0) begin
            p = cnt;
            while (p > 0 && sorted[p-1] > v) begin
              sorted[p] = sorted[p-1];
              p--;
            end
            sorted[p] = v;
            cnt++;
          end
        end
        res.mm = (cnt == 0) ? '0 : sorted[cnt/2];
        res.cnt = CntW'(cnt);
      end
      // scan advances after the result is formed
      if (eos) begin
        cur_slot = (cur_slot + 1) % MaxHistory;
        if (held_scans < MaxHistory - 1) held_scans++;
      end
    end
    return res;
  endfunction

  // true when every older scan in the window holds a written entry for this ray
  function automatic bit ray_has_history(input logic [RayW-1:0] ray);
    int unsigned h;
    if (!flt_en) return 1'b1;
    h = gen_held;
    if (h > eff_window() - 1) h = eff_window() - 1;
    for (int k = 1; k <= h; k++) begin
      if (!gen_written[(gen_slot + MaxHistory - k) % MaxHistory][ray]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // the last ray written while filtering is always safe to read again
  task automatic queue_sample(input logic [RayW-1:0] ray, input logic [RangeW-1:0] mm,
                              input logic eos);
    sample_t smp;
    int unsigned w;
    if (!ray_has_history(ray)) ray = gen_last;
    smp.ray = ray;
    smp.mm = mm;
    smp.eos = eos;
    sample_q.push_back(smp);
    if (flt_en) begin
      w = eff_window();
      if (gen_held > w - 1) gen_held = w - 1;
      gen_written[gen_slot][ray] = 1'b1;
      gen_last = ray;
      if (eos) begin
        gen_slot = (gen_slot + 1) % MaxHistory;
        if (gen_held < MaxHistory - 1) gen_held++;
      end
    end
  endtask

  // no returns, the far end, ties among a few values, and anything
  function automatic logic [RangeW-1:0] draw_mm();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return '1;
      3, 4: return RangeW'(100 * $urandom_range(1, 3));
      default: return RangeW'($urandom);
    endcase
  endfunction

  // well formed scans with random content, a few strays and early scan ends;
  // a full scan over the first rays closes every phase so the next one has history
  task automatic queue_phase(input int n_items, input bit wild);
    int j;
    int len;
    logic [RayW-1:0] base;
    logic eos;
    j = 0;
    len = ScanRays;
    base = '0;
    repeat (n_items) begin
      if (j == 0) begin
        len = wild ? $urandom_range(1, ScanRays) : ScanRays;
        base = wild ? RayW'($urandom) : '0;
      end
      if ($urandom_range(0, 19) == 0) begin
        eos = ($urandom_range(0, 3) == 0);
        queue_sample(RayW'($urandom), draw_mm(), eos);
        if (eos) j = 0;
      end else begin
        eos = (j == len - 1);
        queue_sample(base + RayW'(j), draw_mm(), eos);
        j = eos ? 0 : j + 1;
      end
    end
    for (int r = 0; r < ScanRays; r++) queue_sample(RayW'(r), draw_mm(), r == ScanRays - 1);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tmrf_pkg::CfgFilterEnable) flt_en = val[0];
    else if (idx == tmrf_pkg::CfgWindowSize) win_cfg = val[WinW-1:0];
  endtask

  // everything driven has come back out
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || median_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < PrintLimit)
      $display("tb: mismatch on %s, got %0d, want %0d, at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  function automatic int unsigned pause_len(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MaxPause);
  endfunction

  // input driver: a new sample only once the previous one has transferred
  int unsigned in_gap;
  bit in_quiet;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
      in_quiet <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (sample_q.size() != 0) begin : issue
        sample_t smp;
        smp = sample_q.pop_front();
        ray_index_i <= smp.ray;
        range_mm_i <= smp.mm;
        end_of_scan_i <= smp.eos;
        in_valid_i <= 1'b1;
        in_gap <= pause_len(in_quiet);
        // switch between idling and back to back stretches now and then
        if ($urandom_range(0, 39) == 0) in_quiet <= !in_quiet;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: after each transfer hold ready low for a drawn stall
  int unsigned out_hold;
  bit out_quiet;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold <= 0;
      out_quiet <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin : stall
      int unsigned w;
      w = pause_len(out_quiet);
      out_hold <= w;
      out_ready_i <= (w == 0);
      if ($urandom_range(0, 39) == 0) out_quiet <= !out_quiet;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_ready_i <= (out_hold == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin : watch
      median_t want;
      if (in_valid_i && in_ready_o)
        median_q.push_back(median_of_history(ray_index_i, range_mm_i, end_of_scan_i));
      if (out_valid_o && out_ready_i) begin
        if (median_q.size() == 0) begin
          report_mismatch("unexpected result, ray", out_ray_index_o, 0);
        end else begin
          want = median_q.pop_front();
          if (out_ray_index_o !== want.ray)
            report_mismatch("out_ray_index", out_ray_index_o, want.ray);
          if (filtered_range_mm_o !== want.mm)
            report_mismatch("filtered_range_mm", filtered_range_mm_o, want.mm);
          if (valid_count_o !== want.cnt)
            report_mismatch("valid_count", valid_count_o, want.cnt);
          if (out_end_of_scan_o !== want.eos)
            report_mismatch("out_end_of_scan", out_end_of_scan_o, want.eos);
        end
      end
    end
  end

  // hang detection: cycles in a row without any transfer
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // four rays that toggle every index bit, six scans deep
    logic [RayW-1:0] d_ray [4];
    logic [RangeW-1:0] d_mm [6][4];
    // per phase: enable, window as written, item count, scattered rays
    int ph_en [NumPhases];
    int ph_win [NumPhases];
    int ph_items [NumPhases];
    bit ph_wild [NumPhases];
    logic [CfgDataW-1:0] en_word;

    d_ray = '{10'd0, 10'd1023, 10'd341, 10'd682};
    d_mm = '{
      '{16'hFFFF, 16'd1,    16'd0, 16'h8000},
      '{16'd0,    16'hFFFF, 16'd0, 16'h5555},
      '{16'd1,    16'hAAAA, 16'd0, 16'h8000},
      '{16'd2,    16'd1,    16'd7, 16'h8000},
      '{16'd3,    16'd2,    16'd7, 16'd9},
      '{16'd0,    16'd3,    16'd0, 16'h8000}
    };
    ph_en = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
    ph_win = '{1, 8, 3, 8, 8, 0, 15, 5, 2};
    ph_items = '{90, 150, 110, 110, 90, 110, 150, 110, 80};
    ph_wild = '{1, 0, 0, 0, 1, 1, 0, 0, 0};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, extremes, no returns, ties, all-zero history,
    // and a window that the held scans outgrow
    for (int s = 0; s < 6; s++) begin
      for (int r = 0; r < 4; r++) queue_sample(d_ray[r], d_mm[s][r], r == 3);
    end
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      // upper data bits of the enable word must be ignored
      en_word = CfgDataW'($urandom);
      en_word[0] = ph_en[p][0];
      write_cfg(tmrf_pkg::CfgFilterEnable, en_word);
      write_cfg(tmrf_pkg::CfgWindowSize, CfgDataW'(ph_win[p]));
      queue_phase(ph_items[p], ph_wild[p]);
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
